[rtl/adsr_pkg.sv]
package adsr_pkg;

  // Defaults for the top level parameters.
  localparam int RATE_TABLE_ENTRIES_DEF = 256;
  localparam int ENV_FRACTION_BITS_DEF  = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd4;

  // Operand selections of the shared multiplier.
  localparam int MUL_SEL_W = 3;
  localparam logic [MUL_SEL_W-1:0] MUL_SUS = 3'd0;
  localparam logic [MUL_SEL_W-1:0] MUL_STG = 3'd1;
  localparam logic [MUL_SEL_W-1:0] MUL_K   = 3'd2;
  localparam logic [MUL_SEL_W-1:0] MUL_D   = 3'd3;
  localparam logic [MUL_SEL_W-1:0] MUL_MV  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 latch;
    logic                 mul_en;
    logic [MUL_SEL_W-1:0] mul_sel;
    logic                 sus_ld;
    logic                 stg_ld;
    logic                 lookup;
    logic                 k_ld;
    logic                 env_ld;
    logic                 out_ld;
  } adsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;
  } adsr_sts_t;

  // Integer square root of a 64-bit value, used only while building the rate table.
  function automatic longint unsigned isqrt64(longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    int k;
    v = v_in;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    for (k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

endpackage

[rtl/adsr_ctrl.sv]
module adsr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  adsr_pkg::adsr_sts_t   sts,
  output adsr_pkg::adsr_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SUS_MUL = 4'd1;
  localparam logic [3:0] S_SUS_FIN = 4'd2;
  localparam logic [3:0] S_STG_MUL = 4'd3;
  localparam logic [3:0] S_STG_FIN = 4'd4;
  localparam logic [3:0] S_LOOKUP  = 4'd5;
  localparam logic [3:0] S_K_MUL   = 4'd6;
  localparam logic [3:0] S_K_FIN   = 4'd7;
  localparam logic [3:0] S_D_MUL   = 4'd8;
  localparam logic [3:0] S_ENV_UPD = 4'd9;
  localparam logic [3:0] S_MV_MUL  = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // The block takes a new transaction only between sequences.
  assign in_stall = (state_r != S_IDLE);

  // Step sequence: one multiplier product or one finishing step per state.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_SUS_MUL;
        end
      end
      S_SUS_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = adsr_pkg::MUL_SUS;
        state_nxt   = S_SUS_FIN;
      end
      S_SUS_FIN: begin
        cmd.sus_ld = 1'b1;
        state_nxt  = S_STG_MUL;
      end
      S_STG_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = adsr_pkg::MUL_STG;
        state_nxt   = S_STG_FIN;
      end
      S_STG_FIN: begin
        cmd.stg_ld = 1'b1;
        state_nxt  = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_K_MUL;
      end
      S_K_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = adsr_pkg::MUL_K;
        state_nxt   = S_K_FIN;
      end
      S_K_FIN: begin
        cmd.k_ld  = 1'b1;
        state_nxt = S_D_MUL;
      end
      S_D_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = adsr_pkg::MUL_D;
        state_nxt   = S_ENV_UPD;
      end
      S_ENV_UPD: begin
        cmd.env_ld = 1'b1;
        state_nxt  = S_MV_MUL;
      end
      S_MV_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = adsr_pkg::MUL_MV;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_blocked) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted transaction starts the sequence at once.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SUS_MUL))
    else $error("accepted transaction did not start the sequence");

  // A finished result waits while the output register is still held.
  a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && sts.out_blocked) |=> (state_r == S_OUT))
    else $error("result left the output step while the output was blocked");
`endif

endmodule

[rtl/adsr_dp.sv]
module adsr_dp #(
  parameter int RATE_TABLE_ENTRIES = adsr_pkg::RATE_TABLE_ENTRIES_DEF,
  parameter int ENV_FRACTION_BITS  = adsr_pkg::ENV_FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic signed [14:0]             in_gate_mv,
  input  logic signed [14:0]             in_retrigger_mv,
  input  logic signed [14:0]             in_attack_cv_mv,
  input  logic signed [14:0]             in_decay_cv_mv,
  input  logic signed [14:0]             in_sustain_cv_mv,
  input  logic signed [14:0]             in_release_cv_mv,
  input  adsr_pkg::adsr_cmd_t            cmd,
  output adsr_pkg::adsr_sts_t            sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [13:0]                    out_envelope_mv,
  output logic                           out_attack_lamp,
  output logic                           out_decay_lamp,
  output logic                           out_sustain_lamp,
  output logic                           out_release_lamp
);

  localparam int F  = ENV_FRACTION_BITS;
  localparam int EW = F + 1;
  localparam int IW = $clog2(RATE_TABLE_ENTRIES);
  localparam int XW = 17 + IW;
  localparam int PW = EW + 14;

  localparam logic [EW-1:0] ENV_ONE       = EW'(1) << F;
  localparam logic [EW-1:0] ENV_OVERSHOOT = EW'(((64'd101 << F) + 64'd50) / 64'd100);
  localparam logic [EW-1:0] ENV_NEAR      = EW'(((64'd1 << F) + 64'd500) / 64'd1000);
  localparam logic [16:0]   AMT_ONE       = 17'd65536;
  localparam logic [16:0]   SNAP_LIMIT    = 17'd7;

  // Scaling of a CV to an amount: floor((cv * 4096 + 312) / 625), biased positive.
  localparam logic signed [27:0] AMT_BIAS   = 28'sd67109687;
  localparam logic signed [20:0] AMT_Q_BIAS = 21'sd107375;
  localparam logic [31:0]        RECIP_625  = 32'd219902326;
  localparam int                 RECIP_SH   = 37;

  // Sustain amount to envelope format.
  localparam int SH_L = (F >= 16) ? F - 16 : 0;
  localparam int SH_R = (F < 16) ? 16 - F : 0;
  localparam int WW   = 18 + SH_L;
  localparam logic [WW-1:0] SUS_HALF = WW'((1 << SH_R) >> 1);

  localparam logic [PW:0]   MV_HALF  = (PW + 1)'(1) << (F - 1);
  localparam logic [XW-1:0] LAST_IDX = XW'(RATE_TABLE_ENTRIES - 1);

  localparam logic [1:0] STG_ATTACK  = 2'd0;
  localparam logic [1:0] STG_DECAY   = 2'd1;
  localparam logic [1:0] STG_RELEASE = 2'd2;

  // Rate table, 20000^(1-x)/10 in Q16.16, built at elaboration.
  localparam longint unsigned LOG2_TEN_Q28 = (64'd3321928095 << 28) / 64'd1000000000;
  localparam longint unsigned SPAN_Q28     = (64'd1 << 28) + 64'd4 * LOG2_TEN_Q28;
  localparam longint unsigned TOP_Q28      = (64'd5 << 28) + 64'd3 * LOG2_TEN_Q28;
  localparam longint unsigned LAST_W       = 64'(RATE_TABLE_ENTRIES - 1);

  typedef logic [31:0] rate_tab_t [RATE_TABLE_ENTRIES];

  function automatic rate_tab_t build_rate_tab();
    rate_tab_t       tab;
    longint unsigned root [29];
    longint unsigned u;
    longint unsigned n;
    longint unsigned f;
    longint unsigned m;
    int i;
    int j;
    root[0] = 0;
    root[1] = adsr_pkg::isqrt64(64'd2 << 60);
    for (j = 2; j <= 28; j++) begin
      root[j] = adsr_pkg::isqrt64(root[j-1] << 30);
    end
    for (i = 0; i < RATE_TABLE_ENTRIES; i++) begin
      u = TOP_Q28 - (SPAN_Q28 * 64'(i) + LAST_W / 2) / LAST_W;
      n = u >> 28;
      f = u & ((64'd1 << 28) - 64'd1);
      m = 64'd1 << 30;
      for (j = 1; j <= 28; j++) begin
        if (((f >> (28 - j)) & 64'd1) != 0) begin
          m = (m * root[j] + (64'd1 << 29)) >> 30;
        end
      end
      tab[i] = 32'(((m << n) + (64'd1 << 17)) >> 18);
    end
    return tab;
  endfunction

  localparam rate_tab_t RATE_TAB = build_rate_tab();

  // Biased CV term, always non-negative and below 2^27.
  function automatic logic [26:0] cv_term(logic signed [14:0] cv);
    logic signed [27:0] s;
    s = (28'(cv) <<< 12) + AMT_BIAS;
    return s[26:0];
  endfunction

  // Knob plus scaled CV, clamped to 0..1.
  function automatic logic [16:0] clamp_amt(logic [15:0] knob, logic [17:0] q_off);
    logic signed [20:0] a;
    logic [16:0]        r;
    a = $signed({5'b0, knob}) + $signed({3'b0, q_off}) - AMT_Q_BIAS;
    if (a < 0) begin
      r = '0;
    end else if (a > $signed({4'b0, AMT_ONE})) begin
      r = AMT_ONE;
    end else begin
      r = a[16:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [15:0] attack_knob_r;
  logic [15:0] decay_knob_r;
  logic [15:0] sustain_knob_r;
  logic [15:0] release_knob_r;
  logic [31:0] period_r;

  // Envelope state.
  logic [EW-1:0] env_r;
  logic          decay_r;
  logic          trig_r;

  // Per-transaction working registers.
  logic                gated_r;
  logic signed [14:0]  att_cv_r;
  logic signed [14:0]  dec_cv_r;
  logic signed [14:0]  sus_cv_r;
  logic signed [14:0]  rel_cv_r;
  logic [63:0]         prod_r;
  logic [EW-1:0]       sus_r;
  logic [16:0]         x_r;
  logic [31:0]         rate_r;
  logic [EW-1:0]       tgt_r;
  logic [EW-1:0]       d_r;
  logic                up_r;
  logic [31:0]         k_r;
  logic                kfull_r;

  // Output register.
  logic        out_valid_r;
  logic [13:0] out_mv_r;
  logic        out_att_r;
  logic        out_dec_r;
  logic        out_sus_r;
  logic        out_rel_r;

  logic [1:0]    stage;
  logic [15:0]   stg_knob;
  logic signed [14:0] stg_cv;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [16:0]   amt;
  logic [WW-1:0] sus_wide;
  logic [XW-1:0] idx_w;
  logic [EW-1:0] tgt;
  logic [EW-1:0] mag;
  logic [63:0]   mag_w;
  logic [EW-1:0] env_nxt;
  logic          decay_nxt;
  logic [EW-1:0] gap;
  logic          sustaining;
  logic          resting;
  logic [PW:0]   mv_sum;
  logic [PW:0]   mv_w;
  logic [13:0]   mv_sat;

  // Active stage for this sample.
  always_comb begin
    if (!gated_r) begin
      stage = STG_RELEASE;
    end else if (decay_r) begin
      stage = STG_DECAY;
    end else begin
      stage = STG_ATTACK;
    end
    case (stage)
      STG_ATTACK: begin
        stg_knob = attack_knob_r;
        stg_cv   = att_cv_r;
        tgt      = ENV_OVERSHOOT;
      end
      STG_DECAY: begin
        stg_knob = decay_knob_r;
        stg_cv   = dec_cv_r;
        tgt      = sus_r;
      end
      default: begin
        stg_knob = release_knob_r;
        stg_cv   = rel_cv_r;
        tgt      = '0;
      end
    endcase
  end

  // Operand selection of the shared multiplier.
  always_comb begin
    case (cmd.mul_sel)
      adsr_pkg::MUL_SUS: begin
        mul_a = 32'(cv_term(sus_cv_r));
        mul_b = RECIP_625;
      end
      adsr_pkg::MUL_STG: begin
        mul_a = 32'(cv_term(stg_cv));
        mul_b = RECIP_625;
      end
      adsr_pkg::MUL_K: begin
        mul_a = rate_r;
        mul_b = period_r;
      end
      adsr_pkg::MUL_D: begin
        mul_a = k_r;
        mul_b = 32'(d_r);
      end
      adsr_pkg::MUL_MV: begin
        mul_a = 32'(env_r);
        mul_b = 32'd10000;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Amount from the quotient product; the knob follows the stage being finished.
  always_comb begin
    if (cmd.sus_ld) begin
      amt = clamp_amt(sustain_knob_r, prod_r[RECIP_SH+17:RECIP_SH]);
    end else begin
      amt = clamp_amt(stg_knob, prod_r[RECIP_SH+17:RECIP_SH]);
    end
    sus_wide = WW'(amt);
    if (SH_R > 0) begin
      sus_wide = (sus_wide + SUS_HALF) >> SH_R;
    end else begin
      sus_wide = sus_wide << SH_L;
    end
  end

  // Nearest table entry for the stage amount.
  assign idx_w = x_r * LAST_IDX + XW'(32768);

  // Envelope step toward the target.
  always_comb begin
    mag_w = (prod_r + 64'h0000_0000_FFFF_FFFF) >> 32;
    mag   = kfull_r ? d_r : mag_w[EW-1:0];
    if (x_r < SNAP_LIMIT) begin
      env_nxt = (stage == STG_ATTACK) ? ENV_ONE : tgt_r;
    end else if (up_r) begin
      env_nxt = env_r + mag;
    end else begin
      env_nxt = env_r - mag;
    end
    decay_nxt = decay_r;
    if (stage == STG_ATTACK && env_nxt >= ENV_ONE) begin
      env_nxt   = ENV_ONE;
      decay_nxt = 1'b1;
    end
    if (!gated_r) begin
      decay_nxt = 1'b0;
    end
  end

  // Output value and lamp conditions.
  always_comb begin
    gap        = (env_r >= sus_r) ? env_r - sus_r : sus_r - env_r;
    sustaining = (gap <= ENV_NEAR);
    resting    = (env_r <= ENV_NEAR);
    mv_sum     = (PW + 1)'(prod_r[PW-1:0]) + MV_HALF;
    mv_w       = mv_sum >> F;
    mv_sat     = (mv_w > (PW + 1)'(16383)) ? 14'h3FFF : mv_w[13:0];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_knob_r  <= 16'd32768;
      decay_knob_r   <= 16'd32768;
      sustain_knob_r <= 16'd32768;
      release_knob_r <= 16'd32768;
      period_r       <= 32'd97391;
    end else if (cfg_we) begin
      case (cfg_index)
        adsr_pkg::CFG_ATTACK:  attack_knob_r  <= cfg_data[15:0];
        adsr_pkg::CFG_DECAY:   decay_knob_r   <= cfg_data[15:0];
        adsr_pkg::CFG_SUSTAIN: sustain_knob_r <= cfg_data[15:0];
        adsr_pkg::CFG_RELEASE: release_knob_r <= cfg_data[15:0];
        adsr_pkg::CFG_PERIOD:  period_r       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Envelope state, with the retrigger Schmitt trigger taken at accept time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r   <= '0;
      decay_r <= 1'b0;
      trig_r  <= 1'b0;
    end else begin
      if (cmd.latch) begin
        if (trig_r) begin
          if (in_retrigger_mv <= 15'sd0) begin
            trig_r <= 1'b0;
          end
        end else if (in_retrigger_mv >= 15'sd1000) begin
          trig_r  <= 1'b1;
          decay_r <= 1'b0;
        end
      end
      if (cmd.env_ld) begin
        env_r   <= env_nxt;
        decay_r <= decay_nxt;
      end
    end
  end

  // Working registers of the sequence.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      gated_r  <= (in_gate_mv >= 15'sd1000);
      att_cv_r <= in_attack_cv_mv;
      dec_cv_r <= in_decay_cv_mv;
      sus_cv_r <= in_sustain_cv_mv;
      rel_cv_r <= in_release_cv_mv;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.sus_ld) begin
      sus_r <= sus_wide[EW-1:0];
    end
    if (cmd.stg_ld) begin
      x_r <= amt;
    end
    if (cmd.lookup) begin
      rate_r <= RATE_TAB[idx_w[16 +: IW]];
      tgt_r  <= tgt;
      up_r   <= (tgt >= env_r);
      d_r    <= (tgt >= env_r) ? tgt - env_r : env_r - tgt;
    end
    if (cmd.k_ld) begin
      k_r     <= prod_r[47:16];
      kfull_r <= (prod_r[63:48] != 16'd0);
    end
  end

  // Output register: holds a result until the far side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_mv_r  <= mv_sat;
      out_att_r <= gated_r && !decay_r;
      out_dec_r <= gated_r && decay_r && !sustaining;
      out_sus_r <= gated_r && decay_r && sustaining;
      out_rel_r <= !gated_r && !resting;
    end
  end

  assign sts.out_blocked = out_valid_r && out_stall;
  assign out_valid        = out_valid_r;
  assign out_envelope_mv  = out_mv_r;
  assign out_attack_lamp  = out_att_r;
  assign out_decay_lamp   = out_dec_r;
  assign out_sustain_lamp = out_sus_r;
  assign out_release_lamp = out_rel_r;

`ifndef NO_ASSERTIONS
  // The level never passes the attack target.
  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= ENV_OVERSHOOT)
    else $error("envelope level above the attack target");

  // The decay phase is only reported while gated.
  a_decay_gated: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!decay_r || gated_r))
    else $error("decay phase held without gate");
`endif

endmodule

[rtl/adsr_envelope_generator.sv]
// Channel   Direction  Handshake          Payload
// cfg       in         cfg_we             cfg_index (3), cfg_data (32)
// in        in         in_valid/in_stall  gate, retrigger and four CVs, 15-bit signed mV
// out       out        out_valid/out_stall envelope_mv (14), four stage lamps
//
// A result is loaded once its transaction has run through the whole sequence, and the next
// transaction can be taken only after that result is loaded: five products run in turn
// through the shared 32x32 multiplier, with finishing steps and the rate table read between.
// Reset (rst_n low, synchronous) clears the level and phase and restores the knobs.
// A new transaction is taken while the previous result still waits in the output
// register; a result that finds the output register held waits there until it is free.
module adsr_envelope_generator #(
  parameter int RATE_TABLE_ENTRIES = adsr_pkg::RATE_TABLE_ENTRIES_DEF,
  parameter int ENV_FRACTION_BITS  = adsr_pkg::ENV_FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [14:0]             in_gate_mv,
  input  logic signed [14:0]             in_retrigger_mv,
  input  logic signed [14:0]             in_attack_cv_mv,
  input  logic signed [14:0]             in_decay_cv_mv,
  input  logic signed [14:0]             in_sustain_cv_mv,
  input  logic signed [14:0]             in_release_cv_mv,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [13:0]                    out_envelope_mv,
  output logic                           out_attack_lamp,
  output logic                           out_decay_lamp,
  output logic                           out_sustain_lamp,
  output logic                           out_release_lamp
);

  adsr_pkg::adsr_cmd_t cmd;
  adsr_pkg::adsr_sts_t sts;

  // Sequencer.
  adsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, state and output register.
  adsr_dp #(
    .RATE_TABLE_ENTRIES (RATE_TABLE_ENTRIES),
    .ENV_FRACTION_BITS  (ENV_FRACTION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_gate_mv       (in_gate_mv),
    .in_retrigger_mv  (in_retrigger_mv),
    .in_attack_cv_mv  (in_attack_cv_mv),
    .in_decay_cv_mv   (in_decay_cv_mv),
    .in_sustain_cv_mv (in_sustain_cv_mv),
    .in_release_cv_mv (in_release_cv_mv),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_envelope_mv  (out_envelope_mv),
    .out_attack_lamp  (out_attack_lamp),
    .out_decay_lamp   (out_decay_lamp),
    .out_sustain_lamp (out_sustain_lamp),
    .out_release_lamp (out_release_lamp)
  );

endmodule
